@@ sv/oli_pkg.sv @@
// ----------------------------------------------------------------------------
// oli_pkg: shared types and codes of the ordered list block
// Item structs, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package oli_pkg;

  // Index width of the cell control word; covers lists of up to 128 cells.
  localparam int LIST_IDX_W = 7;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_BACK  = 3'd4;
  localparam logic [2:0] OP_LIST_ALL  = 3'd5;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] element;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_SHL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [LIST_IDX_W-1:0] pos;
    logic [LIST_IDX_W-1:0] tail;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } list_state_t;

endpackage

@@ sv/oli_cell.sv @@
// ----------------------------------------------------------------------------
// oli_cell: one storage cell of the ordered list chain
// Holds one value and takes its next value from itself, a neighbor, the
// inserted value or the head of the list, as the shared control word says.
// ----------------------------------------------------------------------------
module oli_cell
  import oli_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] ins_value,
  input  logic signed [31:0] head_value,
  input  logic signed [31:0] left_value,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] value
);

  localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(IDX);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX == ctl.pos) begin
          value_nxt = ins_value;
        end else if (MY_IDX > ctl.pos) begin
          value_nxt = left_value;
        end
      end
      CELL_SHL: value_nxt = right_value;
      CELL_ROT: begin
        // The tail cell closes the ring by taking the head value.
        value_nxt = (MY_IDX == ctl.tail) ? head_value : right_value;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ sv/ordered_list_insert_delete_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top: ordered list of signed 32-bit values
// A chain of cells keeps up to CAPACITY values, front in cell 0.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid/in_ready with in_item (operation, position,
// value). Results leave on out_valid/out_ready with out_item (status, count,
// element, last). An insert shifts the cells from its position on, a front
// remove shifts the whole chain and a back remove only drops the count;
// such an item's single result appears in the output register the cycle
// after acceptance. A list-all item streams one result per stored value,
// front to back, one per cycle while the receiver takes them; the chain
// rotates by one cell for each result so the head cell always holds the
// next value, and after count rotations the list is back in its original
// order. It occupies the block until its last result is registered, and
// in_ready stays low meanwhile. The single output register lets a new item
// be accepted in the same cycle the previous result is taken. When the
// receiver stalls, the result holds in the output register and no new item
// is accepted. Reset clears the count and the control state; the cell
// contents are left as they are and are only read below the count.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top
  import oli_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  list_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  cell_ctl_t          ctl;
  logic signed [31:0] cell_val [CAPACITY];

  logic             slot_free;
  logic             in_accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  // The output register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign pos_ext = CMP_W'(in_item.position);
  assign cnt_ext = CMP_W'(cnt_r);

  // The chain of cells. Cell 0 has no left neighbor and the last cell no
  // right neighbor; those inputs are never selected in a way that matters.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = in_item.value;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    oli_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  (in_item.value),
      .head_value (cell_val[0]),
      .left_value (left_v),
      .right_value(right_v),
      .value      (cell_val[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ctl.op        = CELL_HOLD;
    ctl.pos       = '0;
    ctl.tail      = LIST_IDX_W'(cnt_r) - LIST_IDX_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.status  = STAT_DONE;
          out_item_nxt.element = '0;
          out_item_nxt.last    = 1'b1;
          out_item_nxt.count   = 5'(cnt_r);
          case (in_item.operation) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              if (in_item.operation == OP_INS_POS && pos_ext > cnt_ext) begin
                out_item_nxt.status = STAT_BADPOS;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                out_item_nxt.status = STAT_FULL;
              end else begin
                ctl.op = CELL_INS;
                if (in_item.operation == OP_INS_FRONT) begin
                  ctl.pos = '0;
                end else if (in_item.operation == OP_INS_BACK) begin
                  ctl.pos = LIST_IDX_W'(cnt_r);
                end else begin
                  ctl.pos = LIST_IDX_W'(CNT_W'(in_item.position));
                end
                cnt_nxt            = cnt_r + CNT_W'(1);
                out_item_nxt.count = 5'(cnt_nxt);
              end
            end
            OP_REM_FRONT, OP_REM_BACK: begin
              if (cnt_r == '0) begin
                out_item_nxt.status = STAT_EMPTY;
              end else begin
                // Removing the back only drops the count.
                if (in_item.operation == OP_REM_FRONT) begin
                  ctl.op = CELL_SHL;
                end
                cnt_nxt            = cnt_r - CNT_W'(1);
                out_item_nxt.count = 5'(cnt_nxt);
              end
            end
            OP_LIST_ALL: begin
              if (cnt_r == '0) begin
                out_item_nxt.status = STAT_EMPTY;
              end else begin
                ctl.op               = CELL_ROT;
                out_item_nxt.element = cell_val[0];
                out_item_nxt.last    = (cnt_r == CNT_W'(1));
                rem_nxt              = cnt_r - CNT_W'(1);
                if (cnt_r != CNT_W'(1)) begin
                  state_nxt = ST_LIST;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          ctl.op               = CELL_ROT;
          out_valid_nxt        = 1'b1;
          out_item_nxt.status  = STAT_DONE;
          out_item_nxt.count   = 5'(cnt_r);
          out_item_nxt.element = cell_val[0];
          out_item_nxt.last    = (rem_r == CNT_W'(1));
          rem_nxt              = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTH
  // The count never exceeds the number of cells.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  // While streaming a list, at least one result is still owed.
  a_list_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LIST |-> rem_r != '0 && cnt_r != '0)
    else $error("list stream with nothing left to send");

  // The count does not move while a list is being streamed.
  a_list_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LIST |=> cnt_r == $past(cnt_r))
    else $error("count changed during list stream");

  // A result that is taken while streaming is followed by the next one.
  a_list_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LIST && slot_free |=> out_valid_r)
    else $error("list stream dropped a result");
`endif

endmodule

@@ test/ordered_list_checker.sv @@
// ----------------------------------------------------------------------------
// ordered_list_checker: result predictor and comparator for the ordered list
// Watches both handshake channels, keeps its own copy of the list, works out
// the results that each accepted item must cause and compares every result
// taken from the block against the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_list_checker
  import oli_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        list_len,
  output int        results_checked,
  output int        full_seen,
  output int        empty_seen
);

  logic signed [31:0] model_vals [CAPACITY];
  int                 model_len = 0;
  out_item_t          pending_results [$];
  int                 n_fail = 0;
  int                 n_checked = 0;
  int                 n_full = 0;
  int                 n_empty = 0;

  assign fail_count      = n_fail;
  assign pending         = pending_results.size();
  assign list_len        = model_len;
  assign results_checked = n_checked;
  assign full_seen       = n_full;
  assign empty_seen      = n_empty;

  // Applies one accepted item to the list copy and queues what it must return.
  task automatic apply_list_op(input in_item_t req);
    out_item_t r;
    int        at;
    int        i;
    r        = '0;
    r.status = STAT_DONE;
    r.last   = 1'b1;
    case (req.operation) inside
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (req.operation == OP_INS_FRONT) at = 0;
        else if (req.operation == OP_INS_BACK) at = model_len;
        else at = int'(req.position);
        // The position check comes before the full check.
        if (at > model_len) begin
          r.status = STAT_BADPOS;
        end else if (model_len >= CAPACITY) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          for (i = model_len; i > at; i--) model_vals[i] = model_vals[i-1];
          model_vals[at] = req.value;
          model_len++;
        end
      end
      OP_REM_FRONT: begin
        if (model_len == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          for (i = 0; i + 1 < model_len; i++) model_vals[i] = model_vals[i+1];
          model_len--;
        end
      end
      OP_REM_BACK: begin
        if (model_len == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          model_len--;
        end
      end
      OP_LIST_ALL: begin
        if (model_len == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          for (i = 0; i < model_len; i++) begin
            r.count   = 5'(model_len);
            r.element = model_vals[i];
            r.last    = (i == model_len - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: begin
        // Unused codes change nothing and return a plain done.
      end
    endcase
    r.count = 5'(model_len);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      model_len = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result status %0d count %0d element %0d last %0b",
                     $time, out_item.status, out_item.count, out_item.element,
                     out_item.last);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status || out_item.count !== want.count ||
              out_item.element !== want.element || out_item.last !== want.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: result mismatch: expected status %0d count %0d element %0d last %0b",
                       $time, want.status, want.count, want.element, want.last);
              $display("%0t:   got status %0d count %0d element %0d last %0b",
                       $time, out_item.status, out_item.count, out_item.element,
                       out_item.last);
            end
          end
        end
      end
      if (in_valid && in_ready) apply_list_op(in_item);
    end
  end

endmodule

@@ test/ordered_list_insert_delete_top_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top_tb: regression for the ordered list block
// Drives a directed sequence and then random list operations with random
// gaps on the input and random stalls on the output, including one long
// output stall; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_list_insert_delete_top_tb;
  import oli_pkg::*;

  localparam int LIST_CAPACITY = 16;

  // Operation codes the block leaves unused; they must act as no-ops.
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int RANDOM_ITEMS = 300;
  localparam int PHASE_ITEMS  = 40;

  // The receiver holds off once for a long stretch after this many results.
  localparam int LONG_HOLD_AT     = 50;
  localparam int LONG_HOLD_CYCLES = 300;

  // Slowest correct run: about 330 items, each with a random input gap and
  // up to 16 results that can each wait out a random output stall, plus the
  // long hold. The limit leaves ample margin over that.
  localparam int CYCLE_LIMIT = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int fail_count;
  int pending;
  int list_len;
  int results_checked;
  int full_seen;
  int empty_seen;

  int cycle_count = 0;
  int items_sent  = 0;

  ordered_list_insert_delete_top #(
    .CAPACITY (LIST_CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // The checker sits beside the block and only watches its ports.
  ordered_list_checker #(
    .CAPACITY (LIST_CAPACITY)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending         (pending),
    .list_len        (list_len),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("ordered_list_insert_delete_top regression: fail");
    $finish;
  end

  function automatic in_item_t make_item(logic [2:0] op, logic [4:0] pos, logic [31:0] val);
    in_item_t it;
    it.operation = op;
    it.position  = pos;
    it.value     = val;
    return it;
  endfunction

  // Builds one random item. Positions mostly fall inside the legal range so
  // that inserts really land at every place in the list; the rest probe the
  // bad-position path. The growing flag biases toward inserts so that phases
  // alternate between running the list up to full and draining it to empty.
  function automatic in_item_t random_list_item(int len, bit growing);
    in_item_t it;
    int       pick;
    it.position = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0:       it.value = 32'h7fff_ffff;
      1:       it.value = 32'h8000_0000;
      default: it.value = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      it.operation = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
    end else if (pick < 12) begin
      it.operation = OP_LIST_ALL;
    end else if ($urandom_range(0, 99) < (growing ? 75 : 25)) begin
      case ($urandom_range(0, 2))
        0:       it.operation = OP_INS_FRONT;
        1:       it.operation = OP_INS_BACK;
        default: begin
          it.operation = OP_INS_POS;
          if ($urandom_range(0, 9) != 0) it.position = 5'($urandom_range(0, len));
        end
      endcase
    end else begin
      it.operation = $urandom_range(0, 1) ? OP_REM_BACK : OP_REM_FRONT;
    end
    return it;
  endfunction

  // Offers one item. It is entered at a falling edge and returns at the
  // falling edge after the item was accepted, so the checker's list length
  // is already up to date when the next item is built. Valid is only
  // lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send(input in_item_t it);
    int gap;
    // Every fourth stretch of 30 items runs with no gaps at all.
    if ((items_sent / 30) % 4 == 3) gap = 0;
    else gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Result sink: after each result it draws a random stall, except in quiet
  // stretches, and once it holds off for a long time so the output register
  // fills and the block must stop taking items.
  initial begin : result_sink
    int taken;
    int hold;
    taken     = 0;
    hold      = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
        else if ((taken / 40) % 3 == 2) hold = 0;
        else hold = $urandom_range(0, 10);
      end
    end
  end

  initial begin : stimulus
    int k;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. An empty list first: listing it, removing from both
    // ends and inserting past the end must all be refused without change.
    send(make_item(OP_LIST_ALL, 5'd0, 32'h0));
    send(make_item(OP_REM_FRONT, 5'd0, 32'h0));
    send(make_item(OP_REM_BACK, 5'd0, 32'h0));
    send(make_item(OP_INS_POS, 5'd1, 32'h0000_0007));
    // The value extremes at the front, back and middle. The front insert
    // carries an all-ones position that the block must ignore.
    send(make_item(OP_INS_FRONT, 5'd31, 32'h7fff_ffff));
    send(make_item(OP_INS_BACK, 5'd0, 32'h8000_0000));
    send(make_item(OP_INS_POS, 5'd1, 32'hffff_ffff));
    // Inserting at a position equal to the count appends at the back.
    send(make_item(OP_INS_POS, 5'd3, 32'h0000_0000));
    // The unused codes return a plain done with the count unchanged.
    send(make_item(OP_UNUSED_6, 5'd21, 32'h5555_5555));
    send(make_item(OP_UNUSED_7, 5'd10, 32'haaaa_aaaa));
    // Fill the list to capacity through all three insert flavors.
    for (k = 0; k < LIST_CAPACITY - 4; k++) begin
      case (k % 3)
        0:       send(make_item(OP_INS_FRONT, 5'd0, $urandom));
        1:       send(make_item(OP_INS_BACK, 5'd0, $urandom));
        default: send(make_item(OP_INS_POS, 5'(list_len / 2), $urandom));
      endcase
    end
    // Full list: an insert is refused as full, but a bad position on a full
    // list must still report bad position, since that check comes first.
    send(make_item(OP_INS_BACK, 5'd0, 32'h1234_5678));
    send(make_item(OP_INS_POS, 5'd31, 32'h1234_5678));
    send(make_item(OP_LIST_ALL, 5'd0, 32'h0));
    send(make_item(OP_REM_FRONT, 5'd0, 32'h0));
    send(make_item(OP_REM_BACK, 5'd0, 32'h0));

    // Random part, in phases that alternately grow and shrink the list.
    for (k = 0; k < RANDOM_ITEMS; k++)
      send(random_list_item(list_len, (k / PHASE_ITEMS) % 2 == 0));
    in_valid <= 1'b0;

    // Drain: every expected result must arrive; the watchdog catches a hang.
    // A list-all can stream up to a full list of results, so a short tail
    // then gives any stray result time to show up.
    while (pending != 0) @(negedge clk);
    repeat (LIST_CAPACITY + 8) @(negedge clk);

    $display("Sent %0d items, checked %0d results; refused as full %0d times, as empty %0d times.",
             items_sent, results_checked, full_seen, empty_seen);
    $display("Mismatches or stray results: %0d, results still outstanding: %0d.",
             fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_list_insert_delete_top regression: pass");
    end else begin
      $display("ordered_list_insert_delete_top regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/oli_pkg.sv
sv/oli_cell.sv
sv/ordered_list_insert_delete_top.sv
test/ordered_list_checker.sv
test/ordered_list_insert_delete_top_tb.sv
